// File: hw/rtl/rtt_pkg.sv
// ----------------------------------------------------------------------------
// rtt_pkg
// Shared types and constants for the repeating timer table.
// ----------------------------------------------------------------------------
package rtt_pkg;

  // Opcodes of an input word
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Most ids emitted on one tick
  localparam int MAX_RESULTS = 16;
  localparam int FIRED_W     = $clog2(MAX_RESULTS + 1);

  // One table entry as held in the table RAM
  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] deadline;
    logic [15:0] period;
    logic [15:0] remaining;
    logic [31:0] order;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Result of the shared lateness/priority compare
  typedef struct packed {
    logic        due;
    logic        better;
    logic [31:0] late;
    logic [31:0] age;
  } cmp_result_t;

endpackage

// File: hw/rtl/rtt_ram.sv
// ----------------------------------------------------------------------------
// rtt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/rtt_cmp.sv
// ----------------------------------------------------------------------------
// rtt_cmp
// Shared compare unit: lateness of one entry and its rank against the best
// candidate found so far in the current pass.
// ----------------------------------------------------------------------------
module rtt_cmp
  import rtt_pkg::*;
(
  input  logic [31:0]  now_seconds,
  input  logic [31:0]  order_base,
  input  logic [31:0]  deadline,
  input  logic [31:0]  order,
  input  logic         best_found,
  input  logic [31:0]  best_late,
  input  logic [31:0]  best_age,
  output cmp_result_t  result
);

  logic [31:0] late;
  logic [31:0] age;

  // Wrapped distances from the deadline and from the insertion order
  assign late = now_seconds - deadline;
  assign age  = order_base - order;

  // Later first, then older first
  assign result.late   = late;
  assign result.age    = age;
  assign result.due    = ~late[31];
  assign result.better = ~best_found || (late > best_late) ||
                         ((late == best_late) && (age > best_age));

endmodule

// File: hw/rtl/repeating_timer_table_top.sv
// ----------------------------------------------------------------------------
// repeating_timer_table_top
// Table of repeating timers with add, remove and one-second tick commands.
// ----------------------------------------------------------------------------
// A worked add or remove keeps in_stall high for one sweep of the table; an add of id 0 or
// period 0, a remove of id 0 and the unused opcode leave the sequencer idle.
// A tick firing k timers takes k+1 sweeps (16 sweeps at the limit of 16), then the flush
// state sends the last word when k > 0; out_stall can hold up sweep ends and the flush.
// Commands are taken one at a time; the next is taken once the sequencer idles.
// Reset clears the valid bits, the seconds count and the order counter, not the table RAM.
// ----------------------------------------------------------------------------
module repeating_timer_table_top
  import rtt_pkg::*;
#(
  parameter int NUM_TIMERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  timer_id,
  input  logic [15:0] period_seconds,
  input  logic [15:0] repeat_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  fired_id,
  output logic        last
);

  localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_END,
    S_FLUSH
  } state_t;

  state_t                 state;
  op_t                    op;
  logic [7:0]             id_q;
  logic [15:0]            period_q;
  logic [15:0]            count_q;
  logic [31:0]            now_seconds;
  logic [31:0]            order_counter;
  logic [31:0]            order_base;
  logic [NUM_TIMERS-1:0]  valid;
  logic [NUM_TIMERS-1:0]  taken;
  logic [CW-1:0]          scan_cnt;
  logic                   rd_vld;
  logic [SW-1:0]          rd_slot;
  logic                   dup;
  logic                   free_found;
  logic [SW-1:0]          free_slot;
  logic                   best_found;
  logic [SW-1:0]          best_slot;
  logic [31:0]            best_late;
  logic [31:0]            best_age;
  logic [7:0]             best_id;
  logic [15:0]            best_period;
  logic [15:0]            best_rem;
  logic                   have_pend;
  logic [7:0]             pend_id;
  logic [FIRED_W-1:0]     n_fired;

  logic                   ram_we;
  logic [SW-1:0]          ram_waddr;
  entry_t                 ram_wentry;
  logic [ENTRY_W-1:0]     ram_rdata;
  entry_t                 rd_entry;
  cmp_result_t            cmp;
  logic                   out_free;
  logic                   advance;
  logic                   scan_last;
  logic                   id_hit;

  assign in_stall  = (state != S_IDLE);
  assign out_free  = ~out_valid | ~out_stall;
  assign advance   = ~have_pend | out_free;
  assign rd_entry  = entry_t'(ram_rdata);
  assign scan_last = rd_vld && (rd_slot == SW'(NUM_TIMERS - 1));
  assign id_hit    = valid[rd_slot] && (rd_entry.id == id_q);

  // Table storage
  rtt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_TIMERS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .raddr (scan_cnt[SW-1:0]),
    .rdata (ram_rdata)
  );

  // Shared compare unit
  rtt_cmp u_cmp (
    .now_seconds (now_seconds),
    .order_base  (order_base),
    .deadline    (rd_entry.deadline),
    .order       (rd_entry.order),
    .best_found  (best_found),
    .best_late   (best_late),
    .best_age    (best_age),
    .result      (cmp)
  );

  // Table write: insert on add, rearm on a fired timer that survives
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = free_slot;
    ram_wentry = '{id: id_q, deadline: now_seconds + {16'd0, period_q},
                   period: period_q, remaining: count_q, order: order_counter};
    if (state == S_END) begin
      if (op == OP_ADD) begin
        ram_we = ~dup & free_found;
      end else if (op == OP_TICK) begin
        ram_we     = best_found && advance && (best_rem != 16'd1);
        ram_waddr  = best_slot;
        ram_wentry = '{id: best_id,
                       deadline: now_seconds + {16'd0, best_period},
                       period: best_period,
                       remaining: (best_rem == 16'd0) ? 16'd0 : best_rem - 16'd1,
                       order: order_counter};
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      now_seconds   <= '0;
      order_counter <= '0;
      valid         <= '0;
      taken         <= '0;
      n_fired       <= '0;
      have_pend     <= 1'b0;
      out_valid     <= 1'b0;
      rd_vld        <= 1'b0;
      best_found    <= 1'b0;
      scan_cnt      <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op         <= op_t'(opcode);
            id_q       <= timer_id;
            period_q   <= period_seconds;
            count_q    <= repeat_count;
            scan_cnt   <= '0;
            rd_vld     <= 1'b0;
            best_found <= 1'b0;
            dup        <= 1'b0;
            free_found <= 1'b0;
            priority case (op_t'(opcode))
              OP_ADD: begin
                if (timer_id != 8'd0 && period_seconds != 16'd0) begin
                  state <= S_SCAN;
                end
              end
              OP_REMOVE: begin
                if (timer_id != 8'd0) begin
                  state <= S_SCAN;
                end
              end
              OP_TICK: begin
                now_seconds <= now_seconds + 32'd1;
                order_base  <= order_counter;
                taken       <= '0;
                n_fired     <= '0;
                have_pend   <= 1'b0;
                state       <= S_SCAN;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        // Sweep the table: issue a read each cycle, evaluate the word returned
        S_SCAN: begin
          rd_vld  <= (scan_cnt < CW'(NUM_TIMERS));
          rd_slot <= scan_cnt[SW-1:0];
          if (scan_cnt < CW'(NUM_TIMERS)) begin
            scan_cnt <= scan_cnt + CW'(1);
          end
          if (rd_vld) begin
            priority case (op)
              OP_ADD: begin
                if (id_hit) begin
                  dup <= 1'b1;
                end
                if (!valid[rd_slot] && !free_found) begin
                  free_found <= 1'b1;
                  free_slot  <= rd_slot;
                end
              end
              OP_REMOVE: begin
                if (id_hit) begin
                  valid[rd_slot] <= 1'b0;
                end
              end
              default: begin
                if (valid[rd_slot] && !taken[rd_slot] && cmp.due && cmp.better) begin
                  best_found  <= 1'b1;
                  best_slot   <= rd_slot;
                  best_late   <= cmp.late;
                  best_age    <= cmp.age;
                  best_id     <= rd_entry.id;
                  best_period <= rd_entry.period;
                  best_rem    <= rd_entry.remaining;
                end
              end
            endcase
          end
          if (scan_last) begin
            state <= S_END;
          end
        end

        // End of a sweep: commit add, or fire the chosen timer
        S_END: begin
          priority case (op)
            OP_ADD: begin
              if (!dup && free_found) begin
                valid[free_slot] <= 1'b1;
                order_counter    <= order_counter + 32'd1;
              end
              state <= S_IDLE;
            end
            OP_REMOVE: begin
              state <= S_IDLE;
            end
            default: begin
              if (best_found) begin
                if (advance) begin
                  if (have_pend) begin
                    out_valid <= 1'b1;
                    fired_id  <= pend_id;
                    last      <= 1'b0;
                  end
                  pend_id          <= best_id;
                  have_pend        <= 1'b1;
                  taken[best_slot] <= 1'b1;
                  n_fired          <= n_fired + FIRED_W'(1);
                  if (best_rem == 16'd1) begin
                    valid[best_slot] <= 1'b0;
                  end else begin
                    order_counter <= order_counter + 32'd1;
                  end
                  scan_cnt   <= '0;
                  rd_vld     <= 1'b0;
                  best_found <= 1'b0;
                  if (n_fired == FIRED_W'(MAX_RESULTS - 1)) begin
                    state <= S_FLUSH;
                  end else begin
                    state <= S_SCAN;
                  end
                end
              end else if (have_pend) begin
                state <= S_FLUSH;
              end else begin
                state <= S_IDLE;
              end
            end
          endcase
        end

        // Send the final word of the tick
        S_FLUSH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            fired_id  <= pend_id;
            last      <= 1'b1;
            have_pend <= 1'b0;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The number of taken bits always equals the fired count
  assert property (@(posedge clk) disable iff (rst)
    $countones(taken) == int'(n_fired))
    else $error("taken bits disagree with fired count");

  // A tick never fires more than the result limit
  assert property (@(posedge clk) disable iff (rst)
    n_fired <= FIRED_W'(MAX_RESULTS))
    else $error("fired count beyond limit");

  // The sweep counter stays within the table
  assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> scan_cnt <= CW'(NUM_TIMERS))
    else $error("sweep counter out of range");

  // Flushing delivers the pending id marked last and empties the pending slot
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) && out_free |=> out_valid && last && !have_pend)
    else $error("flush did not send the last word");

endmodule

// File: dv/repeating_timer_table_top_tb.sv
// ----------------------------------------------------------------------------
// repeating_timer_table_top_tb
// Self-checking bench for the repeating timer table. A behavioral copy of the
// table predicts the fired ids of every tick; the checker compares each output
// word against the oldest prediction. Directed tests cover rejected adds, the
// firing order and a full table, then a long random run mixes adds, removes
// and ticks with random idles and output stalls on both sides.
// ----------------------------------------------------------------------------
module repeating_timer_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rtt_pkg::*;

  localparam int NUM_TIMERS  = 16;
  localparam int HOLD_CYCLES = 400;   // > one worst-case tick (16 sweeps)

  typedef struct packed {
    logic [7:0] id;
    logic       last;
  } fired_word_t;

  // DUT ports
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = OP_NONE;
  logic [7:0]  timer_id = '0;
  logic [15:0] period_seconds = '0;
  logic [15:0] repeat_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  fired_id;
  logic        last;

  // Predicted table state
  bit          tmr_live   [NUM_TIMERS];
  logic [7:0]  tmr_id     [NUM_TIMERS];
  logic [31:0] tmr_due    [NUM_TIMERS];
  logic [15:0] tmr_period [NUM_TIMERS];
  logic [15:0] tmr_left   [NUM_TIMERS];
  logic [31:0] tmr_seq    [NUM_TIMERS];
  logic [31:0] clock_sec = '0;
  logic [31:0] seq_next  = '0;

  fired_word_t due_words_q[$];
  int          mismatches = 0;
  bit          calm = 1'b0;      // no idles, no stalls while set

  repeating_timer_table_top #(.NUM_TIMERS(NUM_TIMERS)) i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .timer_id       (timer_id),
    .period_seconds (period_seconds),
    .repeat_count   (repeat_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .fired_id       (fired_id),
    .last           (last)
  );

  always #2 clk = ~clk;

  // Slot holding a live timer with this id, or -1
  function automatic int find_timer(logic [7:0] id);
    int slot;
    slot = -1;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (tmr_live[i] && tmr_id[i] == id && slot < 0) slot = i;
    end
    return slot;
  endfunction

  // Apply one accepted command to the predicted table, queue the fired ids
  function automatic void advance_table(op_t op, logic [7:0] id, logic [15:0] per,
                                        logic [15:0] cnt);
    int          slot;
    int          best;
    int          n;
    int          s;
    int          picks[MAX_RESULTS];
    bit          taken[NUM_TIMERS];
    logic [31:0] late, age, best_late, best_age;
    fired_word_t w;
    case (op)
      OP_ADD: begin
        if (id != 0 && per != 0 && find_timer(id) < 0) begin
          // lowest free slot
          slot = -1;
          for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (!tmr_live[i]) slot = i;
          end
          if (slot >= 0) begin
            tmr_live[slot]   = 1'b1;
            tmr_id[slot]     = id;
            tmr_period[slot] = per;
            tmr_left[slot]   = cnt;
            tmr_due[slot]    = clock_sec + 32'(per);
            tmr_seq[slot]    = seq_next;
            seq_next++;
          end
        end
      end
      OP_REMOVE: begin
        slot = find_timer(id);
        if (id != 0 && slot >= 0) tmr_live[slot] = 1'b0;
      end
      OP_TICK: begin
        clock_sec++;
        foreach (taken[i]) taken[i] = 1'b0;
        n = 0;
        // pick the most overdue, then the oldest, until nothing is due
        while (n < MAX_RESULTS) begin
          best = -1;
          best_late = '0;
          best_age = '0;
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (tmr_live[i] && !taken[i]) begin
              late = clock_sec - tmr_due[i];
              if (!late[31]) begin
                age = seq_next - tmr_seq[i];
                if (best < 0 || late > best_late ||
                    (late == best_late && age > best_age)) begin
                  best = i;
                  best_late = late;
                  best_age = age;
                end
              end
            end
          end
          if (best < 0) break;
          taken[best] = 1'b1;
          picks[n] = best;
          n++;
        end
        for (int k = 0; k < n; k++) begin
          w.id   = tmr_id[picks[k]];
          w.last = (k == n - 1);
          due_words_q.insert(due_words_q.size(), w);
        end
        // rearm in firing order; a count of one retires the timer
        for (int k = 0; k < n; k++) begin
          s = picks[k];
          if (tmr_left[s] == 16'd1) begin
            tmr_live[s] = 1'b0;
          end else begin
            if (tmr_left[s] != 0) tmr_left[s]--;
            tmr_due[s] = clock_sec + 32'(tmr_period[s]);
            tmr_seq[s] = seq_next;
            seq_next++;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Send one command word, with random idles ahead of it
  task automatic send_word(op_t op, logic [7:0] id, logic [15:0] per, logic [15:0] cnt);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    opcode         <= op;
    timer_id       <= id;
    period_seconds <= per;
    repeat_count   <= cnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_table(op, id, per, cnt);
  endtask

  // Hold off the sender until every predicted word has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_words_q.size() != 0) @(posedge clk);
  endtask

  // Output checker and random output stall
  always @(posedge clk) begin : fired_check
    fired_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_words_q.size() == 0) begin
        $error("unexpected word: fired_id=%0d last=%0d", fired_id, last);
        mismatches++;
      end else begin
        want = due_words_q.pop_front();
        if (fired_id !== want.id) begin
          $error("fired_id: expected %0d, got %0d", want.id, fired_id);
          mismatches++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          mismatches++;
        end
      end
    end
    out_stall <= !calm && ($urandom_range(99) < 31);
  end

  // Dropped adds, removes that miss, the unused opcode, a forever timer
  task automatic test_rejected_adds();
    send_word(OP_ADD, 8'd0, 16'd5, 16'd1);
    send_word(OP_ADD, 8'd7, 16'd0, 16'd1);
    send_word(OP_ADD, 8'd7, 16'd1, 16'd0);
    send_word(OP_ADD, 8'd7, 16'd3, 16'd2);
    send_word(OP_REMOVE, 8'd0, 16'd0, 16'd0);
    send_word(OP_REMOVE, 8'd99, 16'd0, 16'd0);
    send_word(OP_NONE, 8'd255, 16'hffff, 16'hffff);
    send_word(OP_TICK, 8'd0, 16'd0, 16'd0);
    send_word(OP_TICK, 8'd0, 16'd0, 16'd0);
    send_word(OP_REMOVE, 8'd7, 16'd0, 16'd0);
  endtask

  // Overdue timers first, equal deadlines by insertion order
  task automatic test_firing_order();
    send_word(OP_ADD, 8'd3, 16'd2, 16'd1);
    send_word(OP_ADD, 8'd1, 16'd2, 16'd2);
    send_word(OP_ADD, 8'd2, 16'd1, 16'd3);
    send_word(OP_TICK, 8'd0, 16'd0, 16'd0);
    send_word(OP_TICK, 8'd0, 16'd0, 16'd0);
    send_word(OP_TICK, 8'd0, 16'd0, 16'd0);
    send_word(OP_TICK, 8'd0, 16'd0, 16'd0);
  endtask

  // Sixteen timers due at once, an add into the full table is dropped
  task automatic test_full_table();
    drain_results();
    for (int i = 0; i < NUM_TIMERS; i++) begin
      send_word(OP_ADD, 8'(240 + i), 16'd1, (i == NUM_TIMERS - 1) ? 16'hffff : 16'd1);
    end
    send_word(OP_ADD, 8'd200, 16'd1, 16'd1);
    send_word(OP_TICK, 8'd0, 16'd0, 16'd0);
    send_word(OP_REMOVE, 8'd255, 16'd0, 16'd0);
    send_word(OP_ADD, 8'd9, 16'hffff, 16'hffff);
  endtask

  // Mostly well-formed traffic over a small id pool, some noise
  task automatic test_random_traffic();
    int          pick;
    logic [7:0]  id;
    logic [15:0] per;
    logic [15:0] cnt;
    for (int n = 0; n < 443; n++) begin
      calm = (n >= 200 && n < 300);
      if (n == 350) drain_results();
      pick = $urandom_range(99);
      id   = ($urandom_range(19) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(24, 1));
      per  = ($urandom_range(9) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(6, 1));
      case ($urandom_range(7))
        0:       cnt = 16'($urandom_range(65535));
        1, 2:    cnt = 16'd0;
        default: cnt = 16'($urandom_range(4, 1));
      endcase
      if (pick < 38)      send_word(OP_ADD, id, per, cnt);
      else if (pick < 52) send_word(OP_REMOVE, id, per, cnt);
      else if (pick < 96) send_word(OP_TICK, id, per, cnt);
      else if (pick < 98) send_word(OP_NONE, id, per, cnt);
      else                send_word(OP_ADD, id, 16'd0, cnt);
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_rejected_adds();
    test_firing_order();
    test_full_table();
    test_random_traffic();
    drain_results();
    repeat (HOLD_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/rtt_pkg.sv
hw/rtl/rtt_ram.sv
hw/rtl/rtt_cmp.sv
hw/rtl/repeating_timer_table_top.sv
dv/repeating_timer_table_top_tb.sv
